// File: sv/pic_pkg.sv
// Shared types, operation codes and saturation helpers for the 1-D particle push.
// Used by pic_ctrl, pic_dp and the top level; no dependencies.
`default_nettype none
package pic_pkg;

   localparam int FACES_DEF      = 1024;
   localparam int MAX_PASSES_DEF = 10;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_W          = 32;
   localparam int PASS_W         = 7;
   localparam int OP_W           = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUB_STEPS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CRANK      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_WIDTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DOMAIN     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 3'd7;

   // Sequencer steps; the datapath decodes the same codes.
   localparam logic [OP_W-1:0] OP_IDLE    = 5'd0;
   localparam logic [OP_W-1:0] OP_KICK    = 5'd1;
   localparam logic [OP_W-1:0] OP_POS_MUL = 5'd2;
   localparam logic [OP_W-1:0] OP_POS_ADD = 5'd3;
   localparam logic [OP_W-1:0] OP_WRAP_X  = 5'd4;
   localparam logic [OP_W-1:0] OP_WAIT_X  = 5'd5;
   localparam logic [OP_W-1:0] OP_WRAP_H  = 5'd6;
   localparam logic [OP_W-1:0] OP_WAIT_H  = 5'd7;
   localparam logic [OP_W-1:0] OP_IDX_MUL = 5'd8;
   localparam logic [OP_W-1:0] OP_IDX     = 5'd9;
   localparam logic [OP_W-1:0] OP_RD1     = 5'd10;
   localparam logic [OP_W-1:0] OP_RD2     = 5'd11;
   localparam logic [OP_W-1:0] OP_SL_MUL  = 5'd12;
   localparam logic [OP_W-1:0] OP_SLOPE   = 5'd13;
   localparam logic [OP_W-1:0] OP_EP_MUL  = 5'd14;
   localparam logic [OP_W-1:0] OP_EP      = 5'd15;
   localparam logic [OP_W-1:0] OP_V_MUL   = 5'd16;
   localparam logic [OP_W-1:0] OP_V       = 5'd17;
   localparam logic [OP_W-1:0] OP_CX      = 5'd18;
   localparam logic [OP_W-1:0] OP_CV      = 5'd19;
   localparam logic [OP_W-1:0] OP_CHK     = 5'd20;
   localparam logic [OP_W-1:0] OP_SUBEND  = 5'd21;
   localparam logic [OP_W-1:0] OP_OUT     = 5'd22;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              start;
      logic              we;
      logic              load_out;
      logic [PASS_W-1:0] pass;
   } cmd_type;

   typedef struct packed {
      logic       wrap_fast;
      logic       div_done;
      logic       converged;
      logic       out_free;
      logic [7:0] subs;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] a);
      logic signed [31:0] r;
      if (a > $signed({34'd0, 32'h7FFFFFFF})) r = 32'sh7FFFFFFF;
      else if (a < $signed({{34{1'b1}}, 32'h80000000})) r = 32'sh80000000;
      else r = a[31:0];
      return r;
   endfunction

   // Product scaled back to Q16.16 with floor rounding and saturation.
   function automatic logic signed [31:0] qsat(input logic signed [65:0] p);
      return sat32(p >>> 16);
   endfunction

endpackage
`default_nettype wire

// File: sv/pic_div.sv
// Bit-serial remainder unit for the periodic wrap when a step leaves the near periods.
// Standalone; one quotient bit per cycle.
`default_nettype none
module pic_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [34:0] dividend,
   input  wire logic [30:0] divisor,
   output logic             done,
   output logic [30:0]      remainder
);
   logic [34:0] num_ff, num_in;
   logic [30:0] rem_ff, rem_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] rem_sh;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[34]};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = 6'd35;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[33:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) rem_in = 31'(rem_sh - {1'b0, den_ff});
         else rem_in = rem_sh[30:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// File: sv/pic_ctrl.sv
// Sequencer for the particle push: subcycles, Picard passes and the steps of one pass.
// Depends on pic_pkg; drives pic_dp through cmd_type and reads sts_type.
`default_nettype none
module pic_ctrl #(
   parameter int MAX_PASSES = pic_pkg::MAX_PASSES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_func,
   output logic                   req_ready,
   input  wire pic_pkg::sts_type  sts,
   output pic_pkg::cmd_type       cmd
);
   import pic_pkg::*;

   logic [OP_W-1:0]   state_ff, state_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [7:0]        sub_ff, sub_in;
   logic              accept;
   logic              pass_end;

   assign accept    = req_valid && (state_ff == OP_IDLE);
   assign req_ready = (state_ff == OP_IDLE);
   assign pass_end  = sts.converged || ((pass_ff + PASS_W'(1)) == PASS_W'(MAX_PASSES));

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      sub_in   = sub_ff;
      case (state_ff)
         OP_IDLE: begin
            if (accept && req_func) begin
               state_in = OP_KICK;
               pass_in  = '0;
               sub_in   = '0;
            end
         end
         OP_KICK:    state_in = OP_POS_MUL;
         OP_POS_MUL: state_in = OP_POS_ADD;
         OP_POS_ADD: state_in = OP_WRAP_X;
         OP_WRAP_X:  state_in = sts.wrap_fast ? OP_WRAP_H : OP_WAIT_X;
         OP_WAIT_X:  if (sts.div_done) state_in = OP_WRAP_H;
         OP_WRAP_H:  state_in = sts.wrap_fast ? OP_IDX_MUL : OP_WAIT_H;
         OP_WAIT_H:  if (sts.div_done) state_in = OP_IDX_MUL;
         OP_IDX_MUL: state_in = OP_IDX;
         OP_IDX:     state_in = OP_RD1;
         OP_RD1:     state_in = OP_RD2;
         OP_RD2:     state_in = OP_SL_MUL;
         OP_SL_MUL:  state_in = OP_SLOPE;
         OP_SLOPE:   state_in = OP_EP_MUL;
         OP_EP_MUL:  state_in = OP_EP;
         OP_EP:      state_in = OP_V_MUL;
         OP_V_MUL:   state_in = OP_V;
         OP_V:       state_in = OP_CX;
         OP_CX:      state_in = OP_CV;
         OP_CV:      state_in = OP_CHK;
         OP_CHK: begin
            pass_in = pass_ff + PASS_W'(1);
            if (!pass_end) state_in = OP_POS_MUL;
            else if ((sub_ff + 8'd1) >= sts.subs) state_in = OP_OUT;
            else state_in = OP_SUBEND;
         end
         OP_SUBEND: begin
            sub_in   = sub_ff + 8'd1;
            pass_in  = '0;
            state_in = OP_POS_MUL;
         end
         OP_OUT:     if (sts.out_free) state_in = OP_IDLE;
         default:    state_in = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_IDLE;
         pass_ff  <= '0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         sub_ff   <= sub_in;
      end
   end

   always_comb begin
      cmd.op       = state_ff;
      cmd.start    = accept && req_func;
      cmd.we       = accept && !req_func;
      cmd.load_out = (state_ff == OP_OUT) && sts.out_free;
      cmd.pass     = pass_ff;
   end

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != OP_IDLE |-> pass_ff <= PASS_W'(MAX_PASSES))
      else $error("pass counter beyond limit");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.out_free)
      else $error("result loaded over a waiting word");
   a_conv_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == OP_CHK && sts.converged) |=> state_ff != OP_POS_MUL)
      else $error("pass loop continued after convergence");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == OP_WAIT_X && sts.div_done) |=> state_ff == OP_WRAP_H)
      else $error("wrap of position did not advance");
endmodule
`default_nettype wire

// File: sv/pic_dp.sv
// Datapath of the particle push: registers, field table, shared multiplier, wrap, output word.
// Depends on pic_pkg and pic_div; steered by pic_ctrl through cmd_type.
`default_nettype none
module pic_dp #(
   parameter int FACES = pic_pkg::FACES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pic_pkg::cmd_type                  cmd,
   output pic_pkg::sts_type                       sts,
   input  wire logic                              csr_we,
   input  wire logic [pic_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pic_pkg::CSR_W-1:0]         csr_wdata,
   input  wire logic [9:0]                        req_face_index,
   input  wire logic signed [31:0]                req_field_value,
   input  wire logic signed [31:0]                req_start_position,
   input  wire logic signed [31:0]                req_start_velocity,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [31:0]                     rsp_new_position,
   output logic signed [31:0]                     rsp_new_velocity,
   output logic signed [31:0]                     rsp_half_position,
   output logic signed [31:0]                     rsp_half_velocity,
   output logic [3:0]                             rsp_pass_count,
   output logic                                   rsp_wrap_overflow
);
   import pic_pkg::*;

   localparam int AW = $clog2(FACES);

   // Configuration.
   logic [30:0]        dt_ff, cw_ff, inv_ff, len_ff;
   logic signed [31:0] qm_ff;
   logic [7:0]         subs_ff;
   logic               cn_ff;
   logic [31:0]        tol_ff;
   logic [30:0]        cw, len;

   // Working registers.
   logic signed [31:0] x0_ff, v0_ff, x_ff, v_ff, xh_ff, vh_ff, xk_ff, vk_ff;
   logic signed [31:0] kick_ff, e0_ff, e1_ff, ddx_ff, slope_ff, ep_ff, rd_ff;
   logic signed [32:0] xr_ff, hr_ff;
   logic signed [65:0] prod_ff;
   logic [AW-1:0]      idx_ff;
   logic               cx_ff, wneg_ff, ovf_ff;
   logic [31:0]        field_mem [FACES];

   // Output word.
   logic               rv_ff;
   logic signed [31:0] ox_ff, ov_ff, oxh_ff, ovh_ff;
   logic [3:0]         on_ff;
   logic               oo_ff;

   assign cw  = (cw_ff == '0) ? 31'd1 : cw_ff;
   assign len = (len_ff == '0) ? 31'd1 : len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= 31'd65536;
         qm_ff   <= 32'sd65536;
         subs_ff <= 8'd1;
         cn_ff   <= 1'b1;
         cw_ff   <= 31'd65536;
         inv_ff  <= 31'd65536;
         len_ff  <= 31'd67043328;
         tol_ff  <= 32'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STEP_TIME:  dt_ff   <= csr_wdata[30:0];
            CSR_CHARGE:     qm_ff   <= csr_wdata;
            CSR_SUB_STEPS:  subs_ff <= csr_wdata[7:0];
            CSR_CRANK:      cn_ff   <= csr_wdata[0];
            CSR_CELL_WIDTH: cw_ff   <= csr_wdata[30:0];
            CSR_INV_WIDTH:  inv_ff  <= csr_wdata[30:0];
            CSR_DOMAIN:     len_ff  <= csr_wdata[30:0];
            CSR_TOLERANCE:  tol_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Shared multiplier, one product per cycle into prod_ff.
   logic signed [32:0] mul_a, mul_b;
   logic signed [31:0] pos_sel, vel_sel, diff_e;
   logic [32:0]        mag_x, mag_v;

   assign vel_sel = cn_ff ? vh_ff : v_ff;
   assign pos_sel = cn_ff ? xh_ff : x_ff;
   assign diff_e  = sat32(66'(e1_ff) - 66'(e0_ff));
   assign mag_x   = x_ff[31] ? 33'(-$signed({x_ff[31], x_ff})) : {1'b0, x_ff};
   assign mag_v   = v_ff[31] ? 33'(-$signed({v_ff[31], v_ff})) : {1'b0, v_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.start) begin
         mul_a = {2'b0, dt_ff};
         mul_b = 33'(qm_ff);
      end else begin
         case (cmd.op)
            OP_POS_MUL: begin mul_a = {2'b0, dt_ff}; mul_b = 33'(vel_sel); end
            OP_IDX_MUL: begin mul_a = 33'(pos_sel); mul_b = {2'b0, inv_ff}; end
            OP_RD1:     begin mul_a = 33'({1'b0, idx_ff}); mul_b = {2'b0, cw}; end
            OP_SL_MUL:  begin mul_a = 33'(diff_e); mul_b = {2'b0, inv_ff}; end
            OP_EP_MUL:  begin mul_a = 33'(slope_ff); mul_b = 33'(ddx_ff); end
            OP_V_MUL:   begin mul_a = 33'(kick_ff); mul_b = 33'(ep_ff); end
            OP_CX:      begin mul_a = {1'b0, tol_ff}; mul_b = $signed(mag_x); end
            OP_CV:      begin mul_a = {1'b0, tol_ff}; mul_b = $signed(mag_v); end
            default: ;
         endcase
      end
   end

   // Periodic wrap: the near periods resolve at once, farther moves use the divider.
   logic signed [34:0] wy, wt, wl;
   logic               f0, f1, fm, wfast, wsel_h;
   logic [31:0]        wres, fixres;
   logic [34:0]        wmag;
   logic               div_done;
   logic [30:0]        div_rem;

   assign wsel_h = (cmd.op == OP_WRAP_H) || (cmd.op == OP_WAIT_H);
   assign wy     = wsel_h ? 35'(hr_ff) : 35'(xr_ff);
   assign wt     = wy - 35'sd1;
   assign wl     = $signed({4'b0, len});
   assign f0     = !wt[34] && (wt < wl);
   assign f1     = (wt >= wl) && (wt < (wl <<< 1));
   assign fm     = wt[34] && (wt >= -wl);
   assign wfast  = f0 || f1 || fm;
   assign wmag   = wt[34] ? 35'(-wt) : wt;

   always_comb begin
      if (f0) wres = 32'(wt + 35'sd1);
      else if (f1) wres = 32'(wt - wl + 35'sd1);
      else wres = 32'(wt + wl + 35'sd1);
      if (wneg_ff && (div_rem != '0)) fixres = {1'b0, len} - {1'b0, div_rem} + 32'd1;
      else fixres = {1'b0, div_rem} + 32'd1;
   end

   pic_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (((cmd.op == OP_WRAP_X) || (cmd.op == OP_WRAP_H)) && !wfast),
      .dividend  (wmag),
      .divisor   (len),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Index, position sums and velocity update.
   logic [29:0]        idx_raw;
   logic [AW-1:0]      idx_c, rd_addr;
   logic signed [32:0] xr_c, vsum;
   logic signed [33:0] hsum;
   logic signed [31:0] v_c;
   logic signed [48:0] ddx_w;
   logic [16:0]        load_idx;

   assign idx_raw = prod_ff[61:32];
   assign idx_c   = ({2'b0, idx_raw} > 32'(FACES - 2)) ? AW'(FACES - 2) : idx_raw[AW-1:0];
   assign rd_addr = (cmd.op == OP_RD1) ? idx_ff + AW'(1) : idx_c;
   assign xr_c    = 33'(x0_ff) + 33'(qsat(prod_ff));
   assign hsum    = 34'(xr_c) + 34'(x0_ff);
   assign v_c     = sat32(66'(v0_ff) + 66'(qsat(prod_ff)));
   assign vsum    = 33'(v_c) + 33'(v0_ff);
   assign ddx_w   = 49'(pos_sel) - $signed({1'b0, prod_ff[47:0]});
   assign load_idx = {7'b0, req_face_index};

   function automatic logic close(input logic signed [31:0] now,
                                  input logic signed [31:0] prev,
                                  input logic signed [65:0] lim);
      logic signed [32:0] d;
      logic [32:0]        ad;
      d  = 33'(now) - 33'(prev);
      ad = d[32] ? 33'(-d) : d;
      return (ad[32:31] == 2'b0) && ({1'b0, ad[30:0], 32'b0} < lim[63:0]);
   endfunction

   logic conv_c;
   assign conv_c = cx_ff || close(v_ff, vk_ff, prod_ff);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      rd_ff   <= field_mem[rd_addr];
      if (cmd.we && (load_idx < 17'(FACES)))
         field_mem[load_idx[AW-1:0]] <= req_field_value;
      if (cmd.start) begin
         x0_ff <= req_start_position;
         v0_ff <= req_start_velocity;
         v_ff  <= req_start_velocity;
         vh_ff <= req_start_velocity;
         xk_ff <= req_start_position;
         vk_ff <= req_start_velocity;
      end
      case (cmd.op)
         OP_KICK:    kick_ff <= qsat(prod_ff);
         OP_POS_ADD: begin
            xr_ff <= xr_c;
            hr_ff <= hsum[33:1];
         end
         OP_WRAP_X: begin
            x_ff    <= wres;
            wneg_ff <= wt[34];
         end
         OP_WAIT_X:  if (div_done) x_ff <= fixres;
         OP_WRAP_H: begin
            xh_ff   <= wres;
            wneg_ff <= wt[34];
         end
         OP_WAIT_H:  if (div_done) xh_ff <= fixres;
         OP_IDX:     idx_ff <= idx_c;
         OP_RD1:     e0_ff <= rd_ff;
         OP_RD2: begin
            e1_ff  <= rd_ff;
            ddx_ff <= sat32(66'(ddx_w));
         end
         OP_SLOPE:   slope_ff <= qsat(prod_ff);
         OP_EP:      ep_ff <= sat32(66'(e0_ff) + 66'(qsat(prod_ff)));
         OP_V: begin
            v_ff  <= v_c;
            vh_ff <= vsum[32:1];
         end
         OP_CV:      cx_ff <= close(x_ff, xk_ff, prod_ff);
         OP_CHK: begin
            xk_ff <= x_ff;
            vk_ff <= v_ff;
         end
         OP_SUBEND: begin
            x0_ff <= x_ff;
            v0_ff <= v_ff;
            vh_ff <= v_ff;
         end
         default: ;
      endcase
      if (cmd.load_out) begin
         ox_ff  <= x_ff;
         ov_ff  <= v_ff;
         oxh_ff <= xh_ff;
         ovh_ff <= vh_ff;
         on_ff  <= cmd.pass[3:0];
         oo_ff  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff  <= 1'b0;
         ovf_ff <= 1'b0;
      end else begin
         if (cmd.load_out) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
         if (cmd.start) ovf_ff <= 1'b0;
         else if (((cmd.op == OP_WRAP_X) || (cmd.op == OP_WRAP_H)) && !wfast) ovf_ff <= 1'b1;
      end
   end

   always_comb begin
      sts.wrap_fast = wfast;
      sts.div_done  = div_done;
      sts.converged = conv_c;
      sts.out_free  = !rv_ff || rsp_ready;
      sts.subs      = (subs_ff == '0) ? 8'd1 : subs_ff;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_new_position  = ox_ff;
   assign rsp_new_velocity  = ov_ff;
   assign rsp_half_position = oxh_ff;
   assign rsp_half_velocity = ovh_ff;
   assign rsp_pass_count    = on_ff;
   assign rsp_wrap_overflow = oo_ff;
endmodule
`default_nettype wire

// File: sv/pic_particle_push_1d_top.sv
// A load writes the field table when it is accepted. A push runs the kick, then for each pass
// the position update, the wraps, the field lookup, the velocity update and the checks, over all
// subcycles; a wrap that moves more than one period waits for the divider.
// One request is taken at a time; the pass sequence through the shared multiplier sets the rate.
// A finished word waits in the output register while the next item is accepted.
// Reset is synchronous; it clears the sequencer and restores register defaults.
`default_nettype none
module pic_particle_push_1d_top #(
   parameter int FACES      = pic_pkg::FACES_DEF,
   parameter int MAX_PASSES = pic_pkg::MAX_PASSES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [pic_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pic_pkg::CSR_W-1:0]         csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_func,
   input  wire logic [9:0]                        req_face_index,
   input  wire logic signed [31:0]                req_field_value,
   input  wire logic signed [31:0]                req_start_position,
   input  wire logic signed [31:0]                req_start_velocity,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [31:0]                     rsp_new_position,
   output logic signed [31:0]                     rsp_new_velocity,
   output logic signed [31:0]                     rsp_half_position,
   output logic signed [31:0]                     rsp_half_velocity,
   output logic [3:0]                             rsp_pass_count,
   output logic                                   rsp_wrap_overflow
);
   import pic_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pic_ctrl #(.MAX_PASSES(MAX_PASSES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pic_dp #(.FACES(FACES)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_face_index     (req_face_index),
      .req_field_value    (req_field_value),
      .req_start_position (req_start_position),
      .req_start_velocity (req_start_velocity),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_new_position   (rsp_new_position),
      .rsp_new_velocity   (rsp_new_velocity),
      .rsp_half_position  (rsp_half_position),
      .rsp_half_velocity  (rsp_half_velocity),
      .rsp_pass_count     (rsp_pass_count),
      .rsp_wrap_overflow  (rsp_wrap_overflow)
   );
endmodule
`default_nettype wire
